FILE: hw/rtl/grid_dfs_tour_walker_core_assert.svh
// Assertion macros shared by the grid tour walker RTL.
`ifndef GRID_DFS_TOUR_WALKER_CORE_ASSERT_SVH
`define GRID_DFS_TOUR_WALKER_CORE_ASSERT_SVH

// same-cycle implication
`define GDTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gdtw: same-cycle check failed");

// next-cycle implication
`define GDTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gdtw: next-cycle check failed");

`endif

FILE: hw/rtl/gdtw_pkg.sv
// Package: types, constants and helpers of the grid tour walker.
`default_nettype none

package gdtw_pkg;

	localparam int MAX_N   = 64;
	localparam int POS_W   = 6;
	localparam int N_W     = 7;
	localparam int CELLS   = MAX_N * MAX_N;
	localparam int CELL_AW = 2 * POS_W;
	localparam int CNT_W   = CELL_AW + 1;
	localparam int CELL_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_NEXT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [POS_W-1:0] cell_row;
		logic [POS_W-1:0] cell_col;
		logic             is_road;
		logic [3:0]       cell_weight;
	} item_t;

	typedef struct packed {
		logic       move_valid;
		logic [1:0] move_dir;
		logic       is_backtrack;
		logic       walk_done;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [2:0]       nxt;
		logic [1:0]       arr;
	} frame_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_NB,
		ST_NB_WAIT,
		ST_DECIDE,
		ST_VREAD,
		ST_VWRITE,
		ST_POP
	} state_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_DONE,
		RES_MOVE,
		RES_BACK
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      cell_wr;
		logic      idx_clr;
		logic      idx_inc;
		logic      clr_wr;
		logic      start_init;
		logic      nb_rd;
		logic      dec_latch;
		logic      push_wr;
		logic      vis_set;
		logic      pop;
		logic      top_load;
		logic      set_fin;
		logic      res_set;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       nothing;
		logic       found;
		logic       root_only;
		logic       clear_last;
		logic       nb_last;
	} sts_t;

	// neighbor coordinates, 7 bits each; a step off the top or left wraps high
	function automatic logic [2*N_W-1:0] nb_coord(input logic [POS_W-1:0] row,
			input logic [POS_W-1:0] col, input logic [1:0] dir);
		logic [N_W-1:0] nr;
		logic [N_W-1:0] nc;
		nr = {1'b0, row};
		nc = {1'b0, col};
		case (dir)
			DIR_UP:    nr = nr - 7'd1;
			DIR_DOWN:  nr = nr + 7'd1;
			DIR_LEFT:  nc = nc - 7'd1;
			DIR_RIGHT: nc = nc + 7'd1;
			default:   nr = nr;
		endcase
		return {nr, nc};
	endfunction

	function automatic logic [1:0] back_dir(input logic [1:0] dir);
		logic [1:0] r;
		case (dir)
			DIR_UP:    r = DIR_DOWN;
			DIR_DOWN:  r = DIR_UP;
			DIR_LEFT:  r = DIR_RIGHT;
			DIR_RIGHT: r = DIR_LEFT;
			default:   r = DIR_DOWN;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gdtw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module gdtw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gdtw_ctrl.sv
// Controller state machine of the grid tour walker.
`default_nettype none
`include "grid_dfs_tour_walker_core_assert.svh"

module gdtw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  gdtw_pkg::sts_t sts,
	output logic          busy,
	output gdtw_pkg::cmd_t cmd
);
	import gdtw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.kind)
					KIND_START: state_d = ST_CLEAR;
					KIND_NEXT:  state_d = sts.nothing ? ST_IDLE : ST_NB;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_NB: begin
				if (sts.nb_last) state_d = ST_NB_WAIT;
			end
			ST_NB_WAIT: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.found) state_d = ST_VREAD;
				else if (sts.root_only) state_d = ST_IDLE;
				else state_d = ST_POP;
			end
			ST_VREAD:  state_d = ST_VWRITE;
			ST_VWRITE: state_d = ST_IDLE;
			ST_POP:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_kind = RES_ZERO;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
			end
			ST_EXEC: begin
				cmd.idx_clr = 1'b1;
				case (sts.kind)
					KIND_LOAD: begin
						cmd.cell_wr = 1'b1;
						cmd.res_set = 1'b1;
					end
					KIND_START: cmd.res_set = 1'b0;
					KIND_NEXT: begin
						if (sts.nothing) begin
							cmd.set_fin  = 1'b1;
							cmd.res_set  = 1'b1;
							cmd.res_kind = RES_DONE;
						end
					end
					default: cmd.res_set = 1'b1;
				endcase
			end
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.clear_last) begin
					cmd.start_init = 1'b1;
					cmd.res_set    = 1'b1;
				end
			end
			ST_NB: begin
				cmd.nb_rd   = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_DECIDE: begin
				if (sts.found) begin
					cmd.dec_latch = 1'b1;
				end else if (sts.root_only) begin
					cmd.set_fin  = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_DONE;
				end else begin
					cmd.pop      = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_BACK;
				end
			end
			ST_VREAD: begin
				cmd.push_wr = 1'b1;
			end
			ST_VWRITE: begin
				cmd.vis_set  = 1'b1;
				cmd.res_set  = 1'b1;
				cmd.res_kind = RES_MOVE;
			end
			ST_POP: begin
				cmd.top_load = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`GDTW_ASSERT_NXT(a_res_then_idle, clk, arst_n, cmd.res_set, (state_q == ST_IDLE || state_q == ST_POP))
	`GDTW_ASSERT_IMP(a_decide_after_wait, clk, arst_n, state_q == ST_DECIDE, $past(state_q) == ST_NB_WAIT)

endmodule

`default_nettype wire

FILE: hw/rtl/gdtw_dp.sv
// Datapath of the grid tour walker: grid, visited and stack stores, decision logic.
`default_nettype none
`include "grid_dfs_tour_walker_core_assert.svh"

module gdtw_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gdtw_pkg::item_t                    item,
	input  logic                               cfg_we,
	input  logic [gdtw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gdtw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  gdtw_pkg::cmd_t                     cmd,
	output gdtw_pkg::sts_t                     sts,
	output logic                               result_valid,
	output gdtw_pkg::result_t                  result
);
	import gdtw_pkg::*;

	logic [N_W-1:0]    grid_size_q;
	logic [POS_W-1:0]  start_row_q;
	logic [POS_W-1:0]  start_col_q;
	item_t             item_q;
	frame_t            top_q;
	logic [CNT_W-1:0]  count_q;
	logic              fin_q;
	logic [POS_W-1:0]  idx_q;
	logic              rd_vld_s1;
	logic [1:0]        rd_dir_s1;
	logic              rd_ok_s1;
	logic [POS_W-1:0]  rd_col_s1;
	logic [3:0]        nb_road_q;
	logic [3:0]        nb_vis_q;
	logic [3:0]        nb_wt_q [4];
	logic [1:0]        dec_dir_q;
	logic [2:0]        dec_next_q;

	logic [N_W-1:0]    n_eff;
	logic              start_ok;
	logic [1:0]        sel_dir;
	logic [N_W-1:0]    nr7;
	logic [N_W-1:0]    nc7;
	logic              nb_ok;
	logic [POS_W-1:0]  nr6;
	logic [POS_W-1:0]  nc6;
	logic [CELL_W-1:0] cell_wdata;
	logic [CELL_W-1:0] cell_rdata;
	logic              vis_we;
	logic [POS_W-1:0]  vis_waddr;
	logic [MAX_N-1:0]  vis_wdata;
	logic [MAX_N-1:0]  vis_rdata;
	logic [MAX_N-1:0]  clr_row;
	logic [MAX_N-1:0]  one_bit;
	logic [CNT_W-1:0]  count_m1;
	logic [CNT_W-1:0]  count_m2;
	frame_t            push_frame;
	frame_t            stack_rdata;
	logic [2:0]        rank [4];
	logic              any_cand;
	logic [1:0]        best_dir;
	logic [2:0]        best_rank;
	logic              found;

	assign n_eff = (grid_size_q == '0) ? 7'd1 :
		((grid_size_q > N_W'(MAX_N)) ? N_W'(MAX_N) : grid_size_q);
	assign start_ok = ({1'b0, start_row_q} < n_eff) && ({1'b0, start_col_q} < n_eff);

	assign sel_dir    = cmd.nb_rd ? idx_q[1:0] : dec_dir_q;
	assign {nr7, nc7} = nb_coord(top_q.row, top_q.col, sel_dir);
	assign nb_ok      = (nr7 < n_eff) && (nc7 < n_eff);
	assign nr6        = nr7[POS_W-1:0];
	assign nc6        = nc7[POS_W-1:0];
	assign one_bit    = {{(MAX_N-1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= N_W'(MAX_N);
			start_row_q <= '0;
			start_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_SIZE: grid_size_q <= cfg_data;
				REG_START_ROW: start_row_q <= cfg_data[POS_W-1:0];
				REG_START_COL: start_col_q <= cfg_data[POS_W-1:0];
				default:       grid_size_q <= grid_size_q;
			endcase
		end
	end

	// grid store
	assign cell_wdata = item_q.is_road ? {1'b1, item_q.cell_weight} : '0;

	gdtw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cmd.cell_wr),
		.waddr ({item_q.cell_row, item_q.cell_col}),
		.wdata (cell_wdata),
		.raddr ({nr6, nc6}),
		.rdata (cell_rdata)
	);

	// visited store, one grid row per word
	assign clr_row   = (start_ok && idx_q == start_row_q) ? (one_bit << start_col_q) : '0;
	assign vis_we    = cmd.clr_wr | cmd.vis_set;
	assign vis_waddr = cmd.clr_wr ? idx_q : nr6;
	assign vis_wdata = cmd.clr_wr ? clr_row : (vis_rdata | (one_bit << nc6));

	gdtw_ram #(.WIDTH(MAX_N), .DEPTH(MAX_N)) u_vis_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (nr6),
		.rdata (vis_rdata)
	);

	// stack holds the frames below the cached top
	assign count_m1   = count_q - 13'd1;
	assign count_m2   = count_q - 13'd2;
	assign push_frame = '{row: top_q.row, col: top_q.col, nxt: dec_next_q, arr: top_q.arr};

	gdtw_ram #(.WIDTH($bits(frame_t)), .DEPTH(CELLS)) u_stack_ram (
		.clk   (clk),
		.we    (cmd.push_wr),
		.waddr (count_m1[CELL_AW-1:0]),
		.wdata (push_frame),
		.raddr (count_m2[CELL_AW-1:0]),
		.rdata (stack_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		rd_dir_s1 <= idx_q[1:0];
		rd_ok_s1  <= nb_ok;
		rd_col_s1 <= nc6;
		if (rd_vld_s1) begin
			nb_road_q[rd_dir_s1] <= rd_ok_s1 & cell_rdata[CELL_W-1];
			nb_wt_q[rd_dir_s1]   <= cell_rdata[3:0];
			nb_vis_q[rd_dir_s1]  <= vis_rdata[rd_col_s1];
		end
		if (cmd.dec_latch) begin
			dec_dir_q  <= best_dir;
			dec_next_q <= best_rank + 3'd1;
		end
		if (cmd.start_init) begin
			top_q <= '{row: start_row_q, col: start_col_q, nxt: 3'd0, arr: DIR_UP};
		end else if (cmd.vis_set) begin
			top_q <= '{row: nr6, col: nc6, nxt: 3'd0, arr: dec_dir_q};
		end else if (cmd.top_load) begin
			top_q <= stack_rdata;
		end
		if (cmd.res_set) begin
			case (cmd.res_kind)
				RES_DONE: result <= '{move_valid: 1'b0, move_dir: DIR_UP,
					is_backtrack: 1'b0, walk_done: 1'b1};
				RES_MOVE: result <= '{move_valid: 1'b1, move_dir: dec_dir_q,
					is_backtrack: 1'b0, walk_done: 1'b0};
				RES_BACK: result <= '{move_valid: 1'b1, move_dir: back_dir(top_q.arr),
					is_backtrack: 1'b1, walk_done: 1'b0};
				default:  result <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			fin_q        <= 1'b0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			rd_vld_s1    <= cmd.nb_rd;
			result_valid <= cmd.res_set;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 6'd1;
			if (cmd.start_init) begin
				count_q <= start_ok ? 13'd1 : 13'd0;
				fin_q   <= ~start_ok;
			end else if (cmd.vis_set) begin
				count_q <= count_q + 13'd1;
			end else if (cmd.pop) begin
				count_q <= count_m1;
			end
			if (cmd.set_fin) fin_q <= 1'b1;
		end
	end

	// neighbor order: ascending weight, ties by direction index
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rank[i] = 3'd0;
			for (int j = 0; j < 4; j++) begin
				if (nb_road_q[j] && ({nb_wt_q[j], 2'(j)} < {nb_wt_q[i], 2'(i)})) begin
					rank[i] = rank[i] + 3'd1;
				end
			end
		end
	end

	always_comb begin
		any_cand  = 1'b0;
		best_dir  = DIR_UP;
		best_rank = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (nb_road_q[i] && !nb_vis_q[i] && rank[i] >= top_q.nxt &&
					(!any_cand || rank[i] < best_rank)) begin
				any_cand  = 1'b1;
				best_dir  = 2'(i);
				best_rank = rank[i];
			end
		end
	end

	assign found = any_cand && (count_q != CNT_W'(CELLS));

	assign sts.kind       = item_q.kind;
	assign sts.nothing    = fin_q || (count_q == '0);
	assign sts.found      = found;
	assign sts.root_only  = (count_q == 13'd1);
	assign sts.clear_last = (idx_q == POS_W'(MAX_N - 1));
	assign sts.nb_last    = (idx_q == 6'd3);

	`GDTW_ASSERT_NXT(a_push_grows, clk, arst_n, cmd.vis_set, count_q == $past(count_q) + 13'd1)
	`GDTW_ASSERT_IMP(a_pop_keeps_root, clk, arst_n, cmd.pop, count_q >= 13'd2)

endmodule

`default_nettype wire

FILE: hw/rtl/grid_dfs_tour_walker_core.sv
// From accept to result strobe: load, ignored item and ended walk are answered from execute;
// start clears visited rows; next reads neighbors, decides, moves, backtracks or ends.
// busy drops with the strobe, the cycle after on backtrack; one item in flight at a time.
// Neighbors are read one per cycle from the single-read grid store; the visited mark is a
// read-modify-write of one row word; start sweeps 64 visited rows, one per cycle.
// arst_n clears control state and restores register defaults; results cannot be held off.
`default_nettype none

module grid_dfs_tour_walker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  gdtw_pkg::item_t                     item,
	output logic                                busy,
	output logic                                result_valid,
	output gdtw_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gdtw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gdtw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gdtw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	gdtw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	gdtw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
